/* rtl/core/rqy_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqy_pkg
// Shared types and constants for the RGB quad to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package rqy_pkg;

	localparam int PIX_W   = 8;
	localparam int N_LANES = 4;

	// one 2x2 quad of rgb pixels
	typedef struct packed {
		logic [PIX_W-1:0] upper_left_red;
		logic [PIX_W-1:0] upper_left_green;
		logic [PIX_W-1:0] upper_left_blue;
		logic [PIX_W-1:0] upper_right_red;
		logic [PIX_W-1:0] upper_right_green;
		logic [PIX_W-1:0] upper_right_blue;
		logic [PIX_W-1:0] lower_left_red;
		logic [PIX_W-1:0] lower_left_green;
		logic [PIX_W-1:0] lower_left_blue;
		logic [PIX_W-1:0] lower_right_red;
		logic [PIX_W-1:0] lower_right_green;
		logic [PIX_W-1:0] lower_right_blue;
	} quad_t;

	// four lumas and one shared chroma pair
	typedef struct packed {
		logic [PIX_W-1:0] luma_upper_left;
		logic [PIX_W-1:0] luma_upper_right;
		logic [PIX_W-1:0] luma_lower_left;
		logic [PIX_W-1:0] luma_lower_right;
		logic [PIX_W-1:0] blue_chroma;
		logic [PIX_W-1:0] red_chroma;
	} ycc_t;

	// pipeline handshake between top level stages and merge
	typedef struct packed {
		logic load;
	} rqy_ctrl_t;

endpackage

/* rtl/core/rgb_quad_to_ycbcr420.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_quad_to_ycbcr420
// 2x2 RGB quad to four luma bytes and one Cb/Cr pair, JFIF equations.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | payload
//  --------+----------------------------+-----------+---------------------
//  quad    | quad_valid, quad_stall     | in        | quad_t, 12 bytes rgb
//  ycc     | ycc_valid, ycc_stall       | out       | ycc_t, 6 bytes
//
//  one quad per cycle while ycc_stall is low; registered in the lane stage, then the merge stage
//  four pixel lanes run side by side, the merge stage adds their chroma terms
//  arst_n clears the stage valid bits only; payload registers are not reset
//  ycc_stall holds the output register; quad_stall rises only when both
//  stages hold an item and the output is stalled
// ----------------------------------------------------------------------------
module rgb_quad_to_ycbcr420
	import rqy_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  quad_valid,
	output logic  quad_stall,
	input  quad_t quad,
	output logic  ycc_valid,
	input  logic  ycc_stall,
	output ycc_t  ycc
);

	localparam int TW = COEF_FRAC_BITS + 9;

	logic [N_LANES-1:0][PIX_W-1:0]     red, green, blue;
	logic [N_LANES-1:0][PIX_W-1:0]     luma;
	logic signed [N_LANES-1:0][TW-1:0] cb_term, cr_term;

	logic      valid_s1, valid_s2;
	logic      ready_s1, ready_s2;
	logic      load_s1;
	rqy_ctrl_t merge_ctrl;

	assign red[0]   = quad.upper_left_red;
	assign green[0] = quad.upper_left_green;
	assign blue[0]  = quad.upper_left_blue;
	assign red[1]   = quad.upper_right_red;
	assign green[1] = quad.upper_right_green;
	assign blue[1]  = quad.upper_right_blue;
	assign red[2]   = quad.lower_left_red;
	assign green[2] = quad.lower_left_green;
	assign blue[2]  = quad.lower_left_blue;
	assign red[3]   = quad.lower_right_red;
	assign green[3] = quad.lower_right_green;
	assign blue[3]  = quad.lower_right_blue;

	// a stage moves on when the one after it is empty or draining
	assign ready_s2        = !valid_s2 || !ycc_stall;
	assign ready_s1        = !valid_s1 || ready_s2;
	assign quad_stall      = !ready_s1;
	assign load_s1         = quad_valid && ready_s1;
	assign merge_ctrl.load = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= quad_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	for (genvar i = 0; i < N_LANES; i++) begin : g_lane
		rqy_lane #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.load   (load_s1),
			.red    (red[i]),
			.green  (green[i]),
			.blue   (blue[i]),
			.luma   (luma[i]),
			.cb_term(cb_term[i]),
			.cr_term(cr_term[i])
		);
	end

	rqy_merge #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_merge (
		.clk    (clk),
		.ctrl   (merge_ctrl),
		.luma   (luma),
		.cb_term(cb_term),
		.cr_term(cr_term),
		.ycc    (ycc)
	);

	assign ycc_valid = valid_s2;

	// back-pressure reaches the input only with the whole pipe full
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		quad_stall |-> (valid_s1 && valid_s2 && ycc_stall))
		else $error("input stalled while the pipeline had room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(quad_valid && !quad_stall) |=> valid_s1)
		else $error("accepted item did not reach the lane stage");

	a_blocked_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> valid_s1)
		else $error("lane stage item lost while merge stage was blocked");

	a_s1_drains_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> valid_s2)
		else $error("lane stage item did not move to the output");

endmodule

/* rtl/core/rqy_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqy_lane
// One pixel lane: luma byte and the scaled Cb and Cr terms of one pixel.
// ----------------------------------------------------------------------------
module rqy_lane
	import rqy_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         load,
	input  logic [PIX_W-1:0]             red,
	input  logic [PIX_W-1:0]             green,
	input  logic [PIX_W-1:0]             blue,
	output logic [PIX_W-1:0]             luma,
	output logic signed [COEF_FRAC_BITS+8:0] cb_term,
	output logic signed [COEF_FRAC_BITS+8:0] cr_term
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int PW = F + PIX_W;      // coefficient times pixel
	localparam int LW = F + PIX_W + 1;  // luma sum
	localparam int TW = F + PIX_W + 1;  // signed chroma term

	// rounded magnitudes of the coefficients scaled by 2^F
	localparam longint unsigned KYR_L  = ((64'd29900 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KYG_L  = ((64'd58700 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KYB_L  = ((64'd11400 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KCBR_L = ((64'd16874 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KCBG_L = ((64'd33126 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KHALF_L = ((64'd50000 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KCRG_L = ((64'd41869 << F) + 64'd50000) / 64'd100000;
	localparam longint unsigned KCRB_L = ((64'd8131 << F) + 64'd50000) / 64'd100000;

	localparam logic [PW-1:0] KYR   = PW'(KYR_L);
	localparam logic [PW-1:0] KYG   = PW'(KYG_L);
	localparam logic [PW-1:0] KYB   = PW'(KYB_L);
	localparam logic [PW-1:0] KCBR  = PW'(KCBR_L);
	localparam logic [PW-1:0] KCBG  = PW'(KCBG_L);
	localparam logic [PW-1:0] KHALF = PW'(KHALF_L);
	localparam logic [PW-1:0] KCRG  = PW'(KCRG_L);
	localparam logic [PW-1:0] KCRB  = PW'(KCRB_L);

	logic [PW-1:0]        r_ext, g_ext, b_ext;
	logic [PW-1:0]        p_yr, p_yg, p_yb;
	logic [PW-1:0]        p_cbr, p_cbg, p_half_b, p_half_r, p_crg, p_crb;
	logic [LW-1:0]        luma_sum;
	logic [LW-F-1:0]      luma_int;
	logic [PIX_W-1:0]     luma_sat;
	logic signed [TW-1:0] cb_next, cr_next;

	logic [PIX_W-1:0]     luma_s1;
	logic signed [TW-1:0] cb_s1, cr_s1;

	always_comb begin
		r_ext    = PW'(red);
		g_ext    = PW'(green);
		b_ext    = PW'(blue);
		p_yr     = KYR * r_ext;
		p_yg     = KYG * g_ext;
		p_yb     = KYB * b_ext;
		p_cbr    = KCBR * r_ext;
		p_cbg    = KCBG * g_ext;
		p_half_b = KHALF * b_ext;
		p_half_r = KHALF * r_ext;
		p_crg    = KCRG * g_ext;
		p_crb    = KCRB * b_ext;

		luma_sum = LW'(p_yr) + LW'(p_yg) + LW'(p_yb);
		luma_int = luma_sum[LW-1:F];
		// rounded coefficients can overshoot full scale
		if (luma_int > (LW-F)'(255))
			luma_sat = '1;
		else
			luma_sat = luma_int[PIX_W-1:0];

		cb_next = $signed(TW'(p_half_b)) - $signed(TW'(p_cbr)) - $signed(TW'(p_cbg));
		cr_next = $signed(TW'(p_half_r)) - $signed(TW'(p_crg)) - $signed(TW'(p_crb));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			luma_s1 <= luma_sat;
			cb_s1   <= cb_next;
			cr_s1   <= cr_next;
		end
	end

	assign luma    = luma_s1;
	assign cb_term = cb_s1;
	assign cr_term = cr_s1;

endmodule

/* rtl/core/rqy_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqy_merge
// Sums the four lane chroma terms and the offset, floors and clamps to a byte.
// ----------------------------------------------------------------------------
module rqy_merge
	import rqy_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                          clk,
	input  rqy_ctrl_t                                     ctrl,
	input  logic [N_LANES-1:0][PIX_W-1:0]                 luma,
	input  logic signed [N_LANES-1:0][COEF_FRAC_BITS+8:0] cb_term,
	input  logic signed [N_LANES-1:0][COEF_FRAC_BITS+8:0] cr_term,
	output ycc_t                                          ycc
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int SW = F + 12;        // quad sum plus offset, signed
	localparam int VW = SW - F - 2;    // integer part after the divide by four

	// 128 after the divide by four, in the scaled domain
	localparam logic signed [SW-1:0] OFFS = {2'b00, 10'd512, {F{1'b0}}};

	logic signed [SW-1:0] cb_sum, cr_sum;
	ycc_t                 ycc_s2;

	function automatic logic [PIX_W-1:0] sat_byte(input logic signed [SW-1:0] t);
		logic [VW-1:0] v;
		begin
			v = t[SW-1:F+2];
			if (t[SW-1])
				sat_byte = '0;
			else if (v > VW'(255))
				sat_byte = '1;
			else
				sat_byte = v[PIX_W-1:0];
		end
	endfunction

	// an element select of the packed array is unsigned, so sign it again
	always_comb begin
		cb_sum = OFFS;
		cr_sum = OFFS;
		for (int i = 0; i < N_LANES; i++) begin
			cb_sum = cb_sum + SW'($signed(cb_term[i]));
			cr_sum = cr_sum + SW'($signed(cr_term[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ycc_s2.luma_upper_left  <= luma[0];
			ycc_s2.luma_upper_right <= luma[1];
			ycc_s2.luma_lower_left  <= luma[2];
			ycc_s2.luma_lower_right <= luma[3];
			ycc_s2.blue_chroma      <= sat_byte(cb_sum);
			ycc_s2.red_chroma       <= sat_byte(cr_sum);
		end
	end

	assign ycc = ycc_s2;

endmodule

/* tb/tb_rgb_quad_to_ycbcr420.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_quad_to_ycbcr420
// Self-checking bench for the 2x2 RGB quad to YCbCr 4:2:0 converter.
// A queue of quads feeds a clocked driver. Each accepted quad is converted by
// a fixed-point predictor inside the bench, and the predicted bytes wait in
// order. A clocked monitor compares every delivered item field by field.
// The run starts with hand-picked colours, then moves to random quads. The
// phases run several mixes of sender gaps and output stalls, and the bench
// drains fully between phases.
// ----------------------------------------------------------------------------
module tb_rgb_quad_to_ycbcr420;
	import rqy_pkg::*;

	localparam int FRAC = 16;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  quad_valid = 1'b0;
	logic  quad_stall;
	quad_t quad       = '0;
	logic  ycc_valid;
	logic  ycc_stall  = 1'b0;
	ycc_t  ycc;

	quad_t pending_quads[$];
	ycc_t  expected_ycc[$];
	int    sender_idle_pct = 0;
	int    stall_pct       = 0;
	int    n_errors        = 0;

	rgb_quad_to_ycbcr420 #(
		.COEF_FRAC_BITS(FRAC)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.quad_valid(quad_valid),
		.quad_stall(quad_stall),
		.quad      (quad),
		.ycc_valid (ycc_valid),
		.ycc_stall (ycc_stall),
		.ycc       (ycc)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("** rgb_quad_to_ycbcr420: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------------

	// five-decimal coefficient times 2^FRAC, halves rounded away from zero
	function automatic longint coef(longint hundred_thousandths);
		return ((hundred_thousandths << FRAC) + 50000) / 100000;
	endfunction

	function automatic logic [7:0] clamp_byte(longint v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic ycc_t ycc_of_quad(quad_t q);
		longint r[4];
		longint g[4];
		longint b[4];
		longint luma[4];
		longint cb_sum;
		longint cr_sum;
		ycc_t   res;
		r = '{longint'(q.upper_left_red), longint'(q.upper_right_red),
			longint'(q.lower_left_red), longint'(q.lower_right_red)};
		g = '{longint'(q.upper_left_green), longint'(q.upper_right_green),
			longint'(q.lower_left_green), longint'(q.lower_right_green)};
		b = '{longint'(q.upper_left_blue), longint'(q.upper_right_blue),
			longint'(q.lower_left_blue), longint'(q.lower_right_blue)};
		cb_sum = 0;
		cr_sum = 0;
		for (int p = 0; p < 4; p++) begin
			luma[p] = coef(29900) * r[p] + coef(58700) * g[p] + coef(11400) * b[p];
			cb_sum += -coef(16874) * r[p] - coef(33126) * g[p] + coef(50000) * b[p];
			cr_sum += coef(50000) * r[p] - coef(41869) * g[p] - coef(8131) * b[p];
		end
		res.luma_upper_left  = clamp_byte(luma[0] >>> FRAC);
		res.luma_upper_right = clamp_byte(luma[1] >>> FRAC);
		res.luma_lower_left  = clamp_byte(luma[2] >>> FRAC);
		res.luma_lower_right = clamp_byte(luma[3] >>> FRAC);
		// arithmetic shift floors negative sums, which then clamp to zero
		res.blue_chroma = clamp_byte((cb_sum + (longint'(512) << FRAC)) >>> (FRAC + 2));
		res.red_chroma  = clamp_byte((cr_sum + (longint'(512) << FRAC)) >>> (FRAC + 2));
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (quad_valid && !quad_stall)
				expected_ycc.push_back(ycc_of_quad(quad));
			// a stalled item is held as it is
			if (!quad_valid || !quad_stall) begin
				if (pending_quads.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					quad       <= pending_quads.pop_front();
					quad_valid <= 1'b1;
				end else begin
					quad_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin : check_ycc
		ycc_t want;
		if (arst_n) begin
			if (ycc_valid && !ycc_stall) begin
				if (expected_ycc.size() == 0) begin
					report_mismatch("unexpected item", longint'(ycc), longint'(0));
				end else begin
					want = expected_ycc.pop_front();
					if (ycc.luma_upper_left !== want.luma_upper_left)
						report_mismatch("luma_upper_left", longint'(ycc.luma_upper_left),
							longint'(want.luma_upper_left));
					if (ycc.luma_upper_right !== want.luma_upper_right)
						report_mismatch("luma_upper_right", longint'(ycc.luma_upper_right),
							longint'(want.luma_upper_right));
					if (ycc.luma_lower_left !== want.luma_lower_left)
						report_mismatch("luma_lower_left", longint'(ycc.luma_lower_left),
							longint'(want.luma_lower_left));
					if (ycc.luma_lower_right !== want.luma_lower_right)
						report_mismatch("luma_lower_right", longint'(ycc.luma_lower_right),
							longint'(want.luma_lower_right));
					if (ycc.blue_chroma !== want.blue_chroma)
						report_mismatch("blue_chroma", longint'(ycc.blue_chroma),
							longint'(want.blue_chroma));
					if (ycc.red_chroma !== want.red_chroma)
						report_mismatch("red_chroma", longint'(ycc.red_chroma),
							longint'(want.red_chroma));
				end
			end
			ycc_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic quad_t flat_quad(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return '{r, g, b, r, g, b, r, g, b, r, g, b};
	endfunction

	task automatic queue_random_quads(int count);
		quad_t      q;
		int         kind;
		int         v;
		logic [7:0] base[3];
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			for (int c = 0; c < 3; c++)
				base[c] = 8'($urandom_range(0, 255));
			for (int i = 0; i < 12; i++) begin
				if (kind < 6) begin
					v = $urandom_range(0, 255);
				end else if (kind < 8) begin
					// values at or near the ends of the range
					case ($urandom_range(0, 3))
						0:       v = 0;
						1:       v = 255;
						2:       v = $urandom_range(0, 3);
						default: v = $urandom_range(252, 255);
					endcase
				end else begin
					// one colour over the quad with a little jitter
					v = int'(base[i % 3]) + $urandom_range(0, 6) - 3;
					v = (v < 0) ? 0 : (v > 255) ? 255 : v;
				end
				q[8*i +: 8] = v[7:0];
			end
			pending_quads.push_back(q);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_quads.size() != 0 || quad_valid || expected_ycc.size() != 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// primaries, extremes, clamped and negative chroma
		pending_quads.push_back(flat_quad(8'd0, 8'd0, 8'd0));
		pending_quads.push_back(flat_quad(8'd255, 8'd255, 8'd255));
		pending_quads.push_back(flat_quad(8'd255, 8'd0, 8'd0));
		pending_quads.push_back(flat_quad(8'd0, 8'd255, 8'd0));
		pending_quads.push_back(flat_quad(8'd0, 8'd0, 8'd255));
		pending_quads.push_back(flat_quad(8'd255, 8'd255, 8'd0));
		pending_quads.push_back(flat_quad(8'd0, 8'd255, 8'd255));
		pending_quads.push_back(flat_quad(8'd255, 8'd0, 8'd255));
		pending_quads.push_back(flat_quad(8'd1, 8'd0, 8'd0));
		pending_quads.push_back(flat_quad(8'd0, 8'd1, 8'd0));
		pending_quads.push_back(flat_quad(8'd0, 8'd0, 8'd1));
		pending_quads.push_back(flat_quad(8'd128, 8'd128, 8'd128));
		pending_quads.push_back(flat_quad(8'h55, 8'h55, 8'h55));
		pending_quads.push_back(flat_quad(8'hAA, 8'h55, 8'hAA));
		pending_quads.push_back('{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
		pending_quads.push_back('{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0,
			8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
		pending_quads.push_back('{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32,
			8'd64, 8'd128, 8'd3, 8'd254, 8'd127, 8'd200});

		sender_idle_pct = 0;
		stall_pct       = 0;
		queue_random_quads(250);
		wait_drained();

		sender_idle_pct = 70;
		stall_pct       = 0;
		queue_random_quads(260);
		wait_drained();

		sender_idle_pct = 0;
		stall_pct       = 70;
		queue_random_quads(260);
		wait_drained();

		sender_idle_pct = 30;
		stall_pct       = 30;
		queue_random_quads(130);
		// sender holds off until the pipeline has emptied
		wait_drained();
		queue_random_quads(130);
		wait_drained();

		sender_idle_pct = 0;
		stall_pct       = 0;
		queue_random_quads(260);
		wait_drained();

		// catch anything delivered late
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("** rgb_quad_to_ycbcr420: PASSED **");
		else
			$display("** rgb_quad_to_ycbcr420: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/rqy_pkg.sv
rtl/core/rqy_lane.sv
rtl/core/rqy_merge.sv
rtl/core/rgb_quad_to_ycbcr420.sv
tb/tb_rgb_quad_to_ycbcr420.sv
